// ===== sv/base64_encoder_defines.svh =====
// Assertion macros shared by the base64 encoder top level.
`ifndef BASE64_ENCODER_DEFINES_SVH
`define BASE64_ENCODER_DEFINES_SVH

// Checks a property on every clock edge outside of reset.
`define B64_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks a property on every clock edge, reset included.
`define B64_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/b64_pkg.sv =====
// Types, constants and the alphabet lookup for the base64 encoder.
package b64_pkg;

  // Default depth of the queue between the front and back parts.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Largest number of characters one input byte can produce.
  localparam int unsigned CHARS_MAX = 4;

  // Pad character '='.
  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // Group phase codes: bytes taken so far in the current three-byte group.
  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_ONE   = 2'd1,
    PH_TWO   = 2'd2,
    PH_STRAY = 2'd3
  } phase_t;

  // One request's worth of encoded characters, handed from front to back.
  typedef struct packed {
    logic [CHARS_MAX-1:0][7:0] chars;
    logic [1:0]                last_idx;
    logic                      final_flag;
  } b64_rec_t;

  // Maps a 6-bit group to its character of the standard alphabet.
  function automatic logic [7:0] b64_sym(input logic [5:0] six);
    logic [7:0] v;
    v = {2'b00, six};
    if (six < 6'd26) begin
      return 8'd65 + v;
    end else if (six < 6'd52) begin
      return 8'd71 + v;
    end else if (six < 6'd62) begin
      return v - 8'd4;
    end else if (six == 6'd62) begin
      return 8'h2B;
    end else begin
      return 8'h2F;
    end
  endfunction

endpackage

// ===== sv/b64_in_if.sv =====
// Input channel: one raw message byte per request.
interface b64_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_message;

  modport source (output valid, output data_byte, output end_of_message, input ready);
  modport sink (input valid, input data_byte, input end_of_message, output ready);
endinterface

// ===== sv/b64_out_if.sv =====
// Output channel: one encoded character per request.
interface b64_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] ascii_char;
  logic       final_char;

  modport source (output valid, output ascii_char, output final_char, input ready);
  modport sink (input valid, input ascii_char, input final_char, output ready);
endinterface

// ===== sv/b64_front.sv =====
// Front part: takes input bytes, tracks the group phase and builds character records.
module b64_front
  import b64_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  b64_in_if.sink   in_ch,
  output logic     push_valid,
  input  logic     push_ready,
  output b64_rec_t push_rec
);

  phase_t     phase_r, phase_nxt;
  logic [3:0] left_r, left_nxt;
  phase_t     cur_phase;
  phase_t     post_phase;
  logic [3:0] post_left;
  logic       in_fire;
  logic [7:0] b;

  assign b          = in_ch.data_byte;
  assign in_ch.ready = push_ready;
  assign push_valid = in_ch.valid;
  assign in_fire    = in_ch.valid && push_ready;

  // A stray phase is treated as the start of a group.
  assign cur_phase = (phase_r == PH_STRAY) ? PH_START : phase_r;

  // Build the characters this byte completes, plus the tail on the last byte.
  always_comb begin
    push_rec = '0;
    post_phase = PH_START;
    post_left = '0;
    unique case (cur_phase)
      PH_ONE: begin
        push_rec.chars[0] = b64_sym({left_r[1:0], b[7:4]});
        push_rec.last_idx = 2'd0;
        post_phase = PH_TWO;
        post_left = b[3:0];
      end
      PH_TWO: begin
        push_rec.chars[0] = b64_sym({left_r[3:0], b[7:6]});
        push_rec.chars[1] = b64_sym(b[5:0]);
        push_rec.last_idx = 2'd1;
        post_phase = PH_START;
        post_left = '0;
      end
      default: begin
        push_rec.chars[0] = b64_sym(b[7:2]);
        push_rec.last_idx = 2'd0;
        post_phase = PH_ONE;
        post_left = {2'b00, b[1:0]};
      end
    endcase

    push_rec.final_flag = in_ch.end_of_message;
    if (in_ch.end_of_message) begin
      if (post_phase == PH_ONE) begin
        push_rec.chars[1] = b64_sym({b[1:0], 4'b0000});
        push_rec.chars[2] = PAD_CHAR;
        push_rec.chars[3] = PAD_CHAR;
        push_rec.last_idx = 2'd3;
      end else if (post_phase == PH_TWO) begin
        push_rec.chars[1] = b64_sym({b[3:0], 2'b00});
        push_rec.chars[2] = PAD_CHAR;
        push_rec.last_idx = 2'd2;
      end
    end
  end

  // Next state: advance on each accepted request, back to the start after the last byte.
  always_comb begin
    phase_nxt = phase_r;
    left_nxt = left_r;
    if (in_fire) begin
      if (in_ch.end_of_message) begin
        phase_nxt = PH_START;
        left_nxt = '0;
      end else begin
        phase_nxt = post_phase;
        left_nxt = post_left;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      left_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      left_r <= left_nxt;
    end
  end

endmodule

// ===== sv/b64_queue.sv =====
// Short register queue of character records between the front and back parts.
module b64_queue
  import b64_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  output logic     push_ready,
  input  b64_rec_t push_rec,
  output logic     pop_valid,
  input  logic     pop_ready,
  output b64_rec_t pop_rec
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  b64_rec_t           slots [DEPTH];
  logic [IDX_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [IDX_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               push_fire;
  logic               pop_fire;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_rec    = slots[rd_ptr_r];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  // Pointer wrap and fill count.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt = count_r;
    if (push_fire) begin
      wr_ptr_nxt = (wr_ptr_r == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_r + IDX_W'(1);
    end
    if (pop_fire) begin
      rd_ptr_nxt = (rd_ptr_r == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_r + IDX_W'(1);
    end
    if (push_fire && !pop_fire) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop_fire && !push_fire) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  // Record storage needs no reset.
  always_ff @(posedge clk) begin
    if (push_fire) begin
      slots[wr_ptr_r] <= push_rec;
    end
  end

endmodule

// ===== sv/b64_back.sv =====
// Back part: sends the characters of each record one per cycle through an output register, while the output is ready.
module b64_back
  import b64_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     head_valid,
  output logic     head_pop,
  input  b64_rec_t head_rec,
  b64_out_if.source out_ch
);

  logic [1:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] char_r, char_nxt;
  logic       final_r, final_nxt;
  logic       load;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.ascii_char = char_r;
  assign out_ch.final_char = final_r;

  // The output register takes a new character when empty or being drained.
  assign load = !out_valid_r || out_ch.ready;

  always_comb begin
    idx_nxt = idx_r;
    out_valid_nxt = out_valid_r;
    char_nxt = char_r;
    final_nxt = final_r;
    head_pop = 1'b0;
    if (load) begin
      out_valid_nxt = head_valid;
      if (head_valid) begin
        char_nxt = head_rec.chars[idx_r];
        final_nxt = head_rec.final_flag && (idx_r == head_rec.last_idx);
        if (idx_r == head_rec.last_idx) begin
          head_pop = 1'b1;
          idx_nxt = '0;
        end else begin
          idx_nxt = idx_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Character payload needs no reset.
  always_ff @(posedge clk) begin
    char_r <= char_nxt;
    final_r <= final_nxt;
  end

endmodule

// ===== sv/base64_encoder.sv =====
// Streaming base64 encoder (standard alphabet) with '=' padding at the end of a message.
// The first character of an accepted byte goes through a queue slot and then the output register.
// Throughput: one character per cycle while the output is ready; a byte yields one or two
// characters, the last byte up to four, and input is taken every cycle while the queue has room.
// Reset: synchronous active-low rst_n empties the queue and output register, phase to start.
`include "base64_encoder_defines.svh"
module base64_encoder
  import b64_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  b64_in_if.sink    in_ch,
  b64_out_if.source out_ch
);

  logic     push_valid;
  logic     push_ready;
  b64_rec_t push_rec;
  logic     head_valid;
  logic     head_pop;
  b64_rec_t head_rec;

  // Byte intake and character building.
  b64_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_rec   (push_rec)
  );

  // Record queue decoupling intake from output.
  b64_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_rec   (push_rec),
    .pop_valid  (head_valid),
    .pop_ready  (head_pop),
    .pop_rec    (head_rec)
  );

  // Character serializer.
  b64_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_pop   (head_pop),
    .head_rec   (head_rec),
    .out_ch     (out_ch)
  );

  // Only a final record may carry more than two characters.
  `B64_ASSERT(a_short_midmsg,
    (head_valid && !head_rec.final_flag) |-> (head_rec.last_idx <= 2'd1),
    "mid-message record longer than two characters")

  // A non-final pad is followed at once by the final pad.
  `B64_ASSERT(a_pad_pair,
    (out_ch.valid && out_ch.ready && out_ch.ascii_char == PAD_CHAR && !out_ch.final_char)
      |=> (out_ch.valid && out_ch.ascii_char == PAD_CHAR && out_ch.final_char),
    "pad sequence broken")

  // An accepted byte leaves a record waiting in the queue.
  `B64_ASSERT(a_accept_queued, (in_ch.valid && in_ch.ready) |=> head_valid,
    "accepted byte produced no record")

endmodule

// ===== bench/base64_encoder_checker.sv =====
// Checker for the base64 encoder: predicts the character stream and compares each result.
module base64_encoder_checker
  import b64_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_message,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_ascii_char,
  input  logic        out_final_char,
  output int unsigned err_count,
  output int unsigned chars_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // One encoded character as it should leave the block.
  typedef struct packed {
    logic [7:0] ascii_char;
    logic       final_char;
  } enc_char_t;

  // Standard alphabet; index 0 sits in the leftmost byte of the literal.
  localparam logic [0:63][7:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  enc_char_t   expected_chars[$];
  logic [3:0]  carry_bits;
  phase_t      grp_phase;
  int unsigned fail_total;

  function automatic logic [7:0] sextet_char(input logic [5:0] six);
    return ALPHABET[six];
  endfunction

  function automatic void push_char(input logic [7:0] ch);
    enc_char_t c;
    c.ascii_char = ch;
    c.final_char = 1'b0;
    expected_chars.insert(expected_chars.size(), c);
  endfunction

  // Predicts the characters that one accepted byte completes.
  function automatic void encode_byte(input logic [7:0] b, input logic eom);
    enc_char_t tail;
    unique case (grp_phase)
      PH_ONE: begin
        push_char(sextet_char({carry_bits[1:0], b[7:4]}));
        carry_bits = b[3:0];
        grp_phase  = PH_TWO;
      end
      PH_TWO: begin
        push_char(sextet_char({carry_bits, b[7:6]}));
        push_char(sextet_char(b[5:0]));
        carry_bits = 4'd0;
        grp_phase  = PH_START;
      end
      // A stray phase is treated like the start of a group.
      default: begin
        push_char(sextet_char(b[7:2]));
        carry_bits = {2'b00, b[1:0]};
        grp_phase  = PH_ONE;
      end
    endcase

    // The last byte flushes the leftover bits, pads to four and flags the tail.
    if (eom) begin
      if (grp_phase == PH_ONE) begin
        push_char(sextet_char({carry_bits[1:0], 4'b0000}));
        push_char(PAD_CHAR);
        push_char(PAD_CHAR);
      end else if (grp_phase == PH_TWO) begin
        push_char(sextet_char({carry_bits, 2'b00}));
        push_char(PAD_CHAR);
      end
      tail = expected_chars.pop_back();
      tail.final_char = 1'b1;
      expected_chars.insert(expected_chars.size(), tail);
      carry_bits = 4'd0;
      grp_phase  = PH_START;
    end
  endfunction

  // Predict on each input request, compare on each output request.
  always @(posedge clk) begin : watch
    enc_char_t want;
    if (!rst_n) begin
      expected_chars.delete();
      carry_bits    = 4'd0;
      grp_phase     = PH_START;
      fail_total    = 0;
      err_count     <= 0;
      chars_pending <= 0;
    end else begin
      if (in_valid && in_ready) begin
        encode_byte(in_data_byte, in_end_of_message);
      end
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          $error("ascii_char 0x%02h arrived with no character expected", out_ascii_char);
          fail_total++;
        end else begin
          want = expected_chars.pop_front();
          if (out_ascii_char !== want.ascii_char) begin
            $error("ascii_char mismatch: expected 0x%02h, actual 0x%02h",
                   want.ascii_char, out_ascii_char);
            fail_total++;
          end
          if (out_final_char !== want.final_char) begin
            $error("final_char mismatch: expected %0b, actual %0b",
                   want.final_char, out_final_char);
            fail_total++;
          end
        end
      end
      err_count     <= fail_total;
      chars_pending <= expected_chars.size();
    end
  end

endmodule

// ===== bench/base64_encoder_tb.sv =====
// Testbench top for the base64 encoder: clock, reset, byte stimulus, output stalls and verdict.
module base64_encoder_tb;
  import b64_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_BYTES = 250;
  localparam int unsigned QUIET_TAIL   = 40;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DIR_MSGS     = 8;

  // Directed messages: all-zero and all-one bytes, every length modulo three,
  // the two punctuation characters and a message longer than one group.
  localparam logic [7:0] DIR_BYTES [21] = '{8'h00,
                                            8'hFF,
                                            8'h00, 8'hFF,
                                            8'hFF, 8'h00,
                                            8'hFB, 8'hEF, 8'hBE,
                                            8'hFF, 8'hFF, 8'hFF,
                                            8'h00, 8'h00, 8'h00, 8'h00,
                                            8'h4D, 8'h61, 8'h6E, 8'h41, 8'h42};
  localparam int unsigned DIR_LENS [DIR_MSGS] = '{1, 1, 2, 2, 3, 3, 4, 5};

  logic        clk;
  logic        rst_n;
  bit          idle_on = 1'b1;
  int unsigned err_count;
  int unsigned chars_pending;
  int unsigned cycle_count = 0;

  b64_in_if  in_ch ();
  b64_out_if out_ch ();

  base64_encoder u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  base64_encoder_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .in_data_byte     (in_ch.data_byte),
    .in_end_of_message(in_ch.end_of_message),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_ascii_char   (out_ch.ascii_char),
    .out_final_char   (out_ch.final_char),
    .err_count        (err_count),
    .chars_pending    (chars_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Output side: random stall bursts while idling is enabled.
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 2) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Offers one byte request, with an occasional gap ahead of it.
  task automatic send_byte(input logic [7:0] b, input logic eom);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.data_byte      <= b;
    in_ch.end_of_message <= eom;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Holds off the sender until every predicted character has come out.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (chars_pending != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned idx;
    int unsigned sent;
    int unsigned msg_len;

    in_ch.valid          <= 1'b0;
    in_ch.data_byte      <= 8'h00;
    in_ch.end_of_message <= 1'b0;
    rst_n                <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idx = 0;
    for (int m = 0; m < DIR_MSGS; m++) begin
      for (int i = 0; i < DIR_LENS[m]; i++) begin
        send_byte(DIR_BYTES[idx], i == DIR_LENS[m] - 1);
        idx++;
      end
    end
    wait_drained();

    // Random messages, mostly short, now and then a long one.
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      if (sent + QUIET_TAIL >= RANDOM_BYTES) begin
        idle_on = 1'b0;
      end
      if ($urandom_range(0, 7) == 0) begin
        msg_len = $urandom_range(13, 40);
      end else begin
        msg_len = $urandom_range(1, 8);
      end
      for (int i = 0; i < msg_len; i++) begin
        send_byte(8'($urandom_range(0, 255)), i == msg_len - 1);
      end
      sent += msg_len;
      if ($urandom_range(0, 9) == 0) begin
        wait_drained();
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/b64_pkg.sv
sv/b64_in_if.sv
sv/b64_out_if.sv
sv/b64_front.sv
sv/b64_queue.sv
sv/b64_back.sv
sv/base64_encoder.sv
bench/base64_encoder_checker.sv
bench/base64_encoder_tb.sv
